// ===== rtl/core/foq_pkg.sv =====
// ----------------------------------------------------------------------------
// foq_pkg
// Shared codes and types for the fifo / priority queue block.
// ----------------------------------------------------------------------------
package foq_pkg;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    // command codes
    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_REMOVE = 2'd1;
    localparam t_cmd CMD_CLEAR  = 2'd2;

    // status codes
    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_EMPTY = 2'd1;
    localparam t_status STATUS_FULL  = 2'd2;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic write;   // load value_in into the cell at the fill position
        logic shift;   // cells at or above the pick rank take their upper neighbor
        logic scan;    // launch a minimum-search token into the first cell
    } t_cell_ctrl;

    // flags of the search token passed from cell to cell
    typedef struct packed {
        logic valid;   // token present on this link
        logic have;    // token already carries a candidate
    } t_tok_flags;

endpackage

// ===== rtl/core/foq_cmd_if.sv =====
// ----------------------------------------------------------------------------
// foq_cmd_if
// Command channel: one queue command per transfer.
// ----------------------------------------------------------------------------
interface foq_cmd_if
    import foq_pkg::*;
#(
    parameter int VALUE_BITS = 32
);
    logic                  valid;
    logic                  ready;
    t_cmd                  cmd;
    logic [VALUE_BITS-1:0] value_in;

    modport source (output valid, output cmd, output value_in, input ready);
    modport sink   (input valid, input cmd, input value_in, output ready);
endinterface

// ===== rtl/core/foq_res_if.sv =====
// ----------------------------------------------------------------------------
// foq_res_if
// Result channel: one result per accepted command.
// ----------------------------------------------------------------------------
interface foq_res_if
    import foq_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 5
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value_out;
    logic                  value_valid;
    t_status               status;
    logic                  is_empty;
    logic [COUNT_BITS-1:0] entry_count;

    modport source (output valid, output value_out, output value_valid, output status,
                    output is_empty, output entry_count, input ready);
    modport sink   (input valid, input value_out, input value_valid, input status,
                    input is_empty, input entry_count, output ready);
endinterface

// ===== rtl/core/foq_cell.sv =====
// ----------------------------------------------------------------------------
// foq_cell
// One queue slot at a fixed age rank, with its stage of the min-search chain.
// ----------------------------------------------------------------------------
module foq_cell
    import foq_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int VALUE_BITS = 32,
    parameter int RANK_BITS  = 4,
    parameter int COUNT_BITS = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctrl            i_ctrl,
    input  logic [COUNT_BITS-1:0] i_count,
    input  logic [RANK_BITS-1:0]  i_pick,
    input  logic [VALUE_BITS-1:0] i_value_in,
    input  logic [VALUE_BITS-1:0] i_next_value,
    input  t_tok_flags            i_tok_flags,
    input  logic [VALUE_BITS-1:0] i_tok_value,
    input  logic [RANK_BITS-1:0]  i_tok_rank,
    output logic [VALUE_BITS-1:0] o_value,
    output t_tok_flags            o_tok_flags,
    output logic [VALUE_BITS-1:0] o_tok_value,
    output logic [RANK_BITS-1:0]  o_tok_rank
);

    logic [VALUE_BITS-1:0] r_value;
    t_tok_flags            r_tok_flags;
    logic [VALUE_BITS-1:0] r_tok_value;
    logic [RANK_BITS-1:0]  r_tok_rank;

    logic w_occupied;
    logic w_take;

    assign w_occupied = (COUNT_BITS'(IDX) < i_count);

    // newer entry wins ties, so take own value on less-or-equal
    assign w_take = w_occupied && (!i_tok_flags.have || (r_value <= i_tok_value));

    // slot value: append at fill position, close the gap on removal
    always_ff @(posedge i_clk) begin
        if (i_ctrl.write && (i_count == COUNT_BITS'(IDX))) begin
            r_value <= i_value_in;
        end else if (i_ctrl.shift && (RANK_BITS'(IDX) >= i_pick)) begin
            r_value <= i_next_value;
        end
    end

    // search token stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_flags <= '0;
        end else begin
            r_tok_flags.valid <= i_tok_flags.valid;
            r_tok_flags.have  <= i_tok_flags.have || w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_tok_value <= r_value;
            r_tok_rank  <= RANK_BITS'(IDX);
        end else begin
            r_tok_value <= i_tok_value;
            r_tok_rank  <= i_tok_rank;
        end
    end

    assign o_value     = r_value;
    assign o_tok_flags = r_tok_flags;
    assign o_tok_value = r_tok_value;
    assign o_tok_rank  = r_tok_rank;

endmodule

// ===== rtl/core/fifo_or_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// fifo_or_priority_queue_top
// Bounded queue of values with FIFO or smallest-first removal order.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one command per transfer: insert value_in, remove, or clear.
//   o_res returns exactly one result per command: the removed value with its
//   valid flag, a status code, and the entry count and empty flag after the
//   command. i_cfg_we / i_cfg_data write the ordering mode (0 FIFO, 1 smallest
//   value first, newest first among equal values); write it only while idle.
//   Entries sit in a row of cells in arrival order. Insert, clear, FIFO remove
//   and any error result appear in the cycle after the transfer, one command per
//   cycle while the result register drains. An ordered remove sends a search
//   token down the cell row, one cell per cycle; its result is registered once
//   the token leaves the last cell, and no command is taken meanwhile.
//   Reset empties the queue and selects FIFO mode.
//   Results wait in an output register; while the receiver stalls a command
//   is still taken if the waiting result leaves in the same cycle, otherwise
//   i_cmd.ready stays low.
// ----------------------------------------------------------------------------
module fifo_or_priority_queue_top
    import foq_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    foq_cmd_if.sink    i_cmd,
    foq_res_if.source  o_res,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data
);

    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int RANK_BITS  = $clog2(CAPACITY);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                  r_state;
    logic                  n_state;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    logic                  r_ordered_mode;

    logic                  r_res_valid;
    logic [VALUE_BITS-1:0] r_res_value;
    logic                  r_res_value_valid;
    t_status               r_res_status;
    logic                  r_res_is_empty;
    logic [COUNT_BITS-1:0] r_res_count;

    logic                  w_accept;
    logic                  w_res_load;
    logic [VALUE_BITS-1:0] w_res_value;
    logic                  w_res_value_valid;
    t_status               w_res_status;
    t_cell_ctrl            w_ctrl;
    logic [RANK_BITS-1:0]  w_pick;

    logic [VALUE_BITS-1:0] w_value     [CAPACITY+1];
    t_tok_flags            w_tok_flags [CAPACITY+1];
    logic [VALUE_BITS-1:0] w_tok_value [CAPACITY+1];
    logic [RANK_BITS-1:0]  w_tok_rank  [CAPACITY+1];

    // handshake
    assign i_cmd.ready = (r_state == ST_IDLE) && (!r_res_valid || o_res.ready);
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    // search token enters the first cell empty-handed
    assign w_tok_flags[0].valid = w_ctrl.scan;
    assign w_tok_flags[0].have  = 1'b0;
    assign w_tok_value[0]       = '0;
    assign w_tok_rank[0]        = '0;
    assign w_value[CAPACITY]    = '0;

    // row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        foq_cell #(
            .IDX        (g),
            .VALUE_BITS (VALUE_BITS),
            .RANK_BITS  (RANK_BITS),
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_count      (r_count),
            .i_pick       (w_pick),
            .i_value_in   (i_cmd.value_in),
            .i_next_value (w_value[g+1]),
            .i_tok_flags  (w_tok_flags[g]),
            .i_tok_value  (w_tok_value[g]),
            .i_tok_rank   (w_tok_rank[g]),
            .o_value      (w_value[g]),
            .o_tok_flags  (w_tok_flags[g+1]),
            .o_tok_value  (w_tok_value[g+1]),
            .o_tok_rank   (w_tok_rank[g+1])
        );
    end

    // command decode and sequencing
    always_comb begin
        n_state           = r_state;
        n_count           = r_count;
        w_ctrl            = '0;
        w_pick            = '0;
        w_res_load        = 1'b0;
        w_res_value       = '0;
        w_res_value_valid = 1'b0;
        w_res_status      = STATUS_OK;
        if (w_accept) begin
            case (i_cmd.cmd)
                CMD_INSERT: begin
                    w_res_load = 1'b1;
                    if (r_count == COUNT_BITS'(CAPACITY)) begin
                        w_res_status = STATUS_FULL;
                    end else begin
                        w_ctrl.write = 1'b1;
                        n_count      = r_count + 1'b1;
                    end
                end
                CMD_REMOVE: begin
                    if (r_count == '0) begin
                        w_res_load   = 1'b1;
                        w_res_status = STATUS_EMPTY;
                    end else if (!r_ordered_mode) begin
                        w_res_load        = 1'b1;
                        w_res_value       = w_value[0];
                        w_res_value_valid = 1'b1;
                        w_ctrl.shift      = 1'b1;
                        n_count           = r_count - 1'b1;
                    end else begin
                        w_ctrl.scan = 1'b1;
                        n_state     = ST_SCAN;
                    end
                end
                CMD_CLEAR: begin
                    w_res_load = 1'b1;
                    n_count    = '0;
                end
                default: begin
                    w_res_load = 1'b1;
                end
            endcase
        end else if ((r_state == ST_SCAN) && w_tok_flags[CAPACITY].valid) begin
            // token left the last cell: remove the winner and close the gap
            w_pick            = w_tok_rank[CAPACITY];
            w_ctrl.shift      = 1'b1;
            w_res_load        = 1'b1;
            w_res_value       = w_tok_value[CAPACITY];
            w_res_value_valid = 1'b1;
            n_count           = r_count - 1'b1;
            n_state           = ST_IDLE;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_count        <= '0;
            r_ordered_mode <= 1'b0;
            r_res_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_ordered_mode <= i_cfg_data;
            end
            if (w_res_load) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_res_value       <= w_res_value;
            r_res_value_valid <= w_res_value_valid;
            r_res_status      <= w_res_status;
            r_res_is_empty    <= (n_count == '0);
            r_res_count       <= n_count;
        end
    end

    assign o_res.valid       = r_res_valid;
    assign o_res.value_out   = r_res_value;
    assign o_res.value_valid = r_res_value_valid;
    assign o_res.status      = r_res_status;
    assign o_res.is_empty    = r_res_is_empty;
    assign o_res.entry_count = r_res_count;

endmodule

// ===== bench/foq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// foq_checker
// Watches the command, result and mode-write ports of the queue, keeps its
// own copy of the queue contents and ordering mode, predicts one result per
// accepted command and compares every result transfer against the oldest
// prediction. Hands the mismatch count and the number of outstanding
// predictions to the bench top.
// ----------------------------------------------------------------------------
module foq_checker
    import foq_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = $clog2(CAPACITY + 1)
) (
    input  logic i_clk,
    input  logic i_rst_n,
    foq_cmd_if   i_cmd,
    foq_res_if   i_res,
    input  logic i_cfg_we,
    input  logic i_cfg_data,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [VALUE_BITS-1:0] value_out;
        logic                  value_valid;
        t_status               status;
        logic                  is_empty;
        logic [COUNT_BITS-1:0] entry_count;
    } t_queue_result;

    // held values in arrival order, oldest at index 0
    logic [VALUE_BITS-1:0] held_values[$];
    logic                  smallest_first = 1'b0;
    t_queue_result         result_q[$];
    t_queue_result         got_result;
    t_queue_result         want_result;
    int                    mismatches = 0;

    // apply one command to the shadow queue and return its result
    function automatic t_queue_result step_queue(t_cmd c, logic [VALUE_BITS-1:0] v);
        t_queue_result r;
        int            pick;
        r        = '0;
        r.status = STATUS_OK;
        case (c)
            CMD_INSERT: begin
                if (held_values.size() >= CAPACITY)
                    r.status = STATUS_FULL;
                else
                    held_values.push_back(v);
            end
            CMD_REMOVE: begin
                if (held_values.size() == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    pick = 0;
                    // smallest wins, later arrival wins a tie
                    if (smallest_first)
                        for (int i = 1; i < held_values.size(); i++)
                            if (held_values[i] <= held_values[pick])
                                pick = i;
                    r.value_out   = held_values[pick];
                    r.value_valid = 1'b1;
                    held_values.delete(pick);
                end
            end
            CMD_CLEAR: held_values.delete();
            default: ;
        endcase
        r.is_empty    = (held_values.size() == 0);
        r.entry_count = COUNT_BITS'(held_values.size());
        return r;
    endfunction

    // sample transfers on the clock edge; results first, they belong to older commands
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_values.delete();
            result_q.delete();
            smallest_first = 1'b0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                got_result.value_out   = i_res.value_out;
                got_result.value_valid = i_res.value_valid;
                got_result.status      = i_res.status;
                got_result.is_empty    = i_res.is_empty;
                got_result.entry_count = i_res.entry_count;
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result transfer: value %h valid %b status %0d",
                             $time, got_result.value_out, got_result.value_valid,
                             got_result.status,
                             " empty %b count %0d",
                             got_result.is_empty, got_result.entry_count);
                    mismatches++;
                end else begin
                    want_result = result_q.pop_front();
                    if (got_result !== want_result) begin
                        $display("%0t: mismatch: expected value %h valid %b status %0d",
                                 $time, want_result.value_out, want_result.value_valid,
                                 want_result.status,
                                 " empty %b count %0d,",
                                 want_result.is_empty, want_result.entry_count,
                                 " got value %h valid %b status %0d",
                                 got_result.value_out, got_result.value_valid,
                                 got_result.status,
                                 " empty %b count %0d",
                                 got_result.is_empty, got_result.entry_count);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we)
                smallest_first = i_cfg_data;
            if (i_cmd.valid && i_cmd.ready)
                result_q.push_back(step_queue(i_cmd.cmd, i_cmd.value_in));
        end
        o_pending    <= result_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the fifo / priority queue: a directed opening covering the
// empty, full, clear, unused-command and mode-switch cases, then random
// command streams in phases of differing sender idling and receiver stalls,
// with the ordering mode rewritten between phases while entries are held.
// ----------------------------------------------------------------------------
module tb_top;
    import foq_pkg::*;

    localparam int   CAPACITY     = 16;
    localparam int   VALUE_BITS   = 32;
    localparam int   COUNT_BITS   = $clog2(CAPACITY + 1);
    localparam t_cmd CMD_SPARE    = 2'd3;
    localparam int   SEGMENTS     = 12;
    localparam int   SEGMENT_LEN  = 158;
    localparam int   RUN_LIMIT_NS = 2_000_000;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_data;
    int   fail_count;
    int   pending;
    int   sender_idle_pct = 0;
    int   recv_stall_pct  = 0;

    foq_cmd_if #(.VALUE_BITS(VALUE_BITS)) cmd_bus ();
    foq_res_if #(.VALUE_BITS(VALUE_BITS), .COUNT_BITS(COUNT_BITS)) res_bus ();

    fifo_or_priority_queue_top #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cmd      (cmd_bus),
        .o_res      (res_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    foq_checker #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) queue_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd        (cmd_bus),
        .i_res        (res_bus),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver stalls
    always @(posedge clk) begin
        res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // one command transfer, preceded by a random idle gap
    task automatic apply_cmd(input t_cmd c, input logic [VALUE_BITS-1:0] v);
        while ($urandom_range(99) < sender_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid    <= 1'b1;
        cmd_bus.cmd      <= c;
        cmd_bus.value_in <= v;
        do @(posedge clk); while (!cmd_bus.ready);
    endtask

    // stop sending and wait for every outstanding result
    task automatic idle_drain();
        cmd_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // rewrite the ordering mode once the queue is idle
    task automatic write_mode(input logic m);
        idle_drain();
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // values: a tight pool for ties, the top of the range, or anything
    function automatic logic [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(3))
            0:       return $urandom_range(7);
            1:       return '1 - $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_cmd pick_cmd(input int insert_pct);
        int r;
        r = $urandom_range(99);
        if (r < 1)
            return CMD_CLEAR;
        else if (r < 2)
            return CMD_SPARE;
        else if (r < 2 + insert_pct)
            return CMD_INSERT;
        else
            return CMD_REMOVE;
    endfunction

    initial begin
        int seg;
        int n;
        int insert_pct;
        cmd_bus.valid    <= 1'b0;
        cmd_bus.cmd      <= CMD_INSERT;
        cmd_bus.value_in <= '0;
        cfg_we           <= 1'b0;
        cfg_data         <= 1'b0;
        rst_n            <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty remove, value extremes, unused command, clear
        apply_cmd(CMD_REMOVE, 32'h1234_5678);
        apply_cmd(CMD_INSERT, '0);
        apply_cmd(CMD_INSERT, '1);
        apply_cmd(CMD_SPARE, 32'hA5A5_5A5A);
        apply_cmd(CMD_REMOVE, '1);
        apply_cmd(CMD_CLEAR, '1);

        // fill with repeated values, then insert on full
        for (int k = 0; k < CAPACITY; k++)
            apply_cmd(CMD_INSERT, k[0] ? 32'd5 : 32'hFFFF_FFF0 - k);
        apply_cmd(CMD_INSERT, 32'hDEAD_BEEF);

        // switch to smallest-first with a full queue, ties go to the newest
        write_mode(1'b1);
        repeat (3) apply_cmd(CMD_REMOVE, '0);

        // random phases, mode rewritten with entries held
        for (seg = 0; seg < SEGMENTS; seg++) begin
            case (seg % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin sender_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            write_mode(seg == 0 ? 1'b0 : seg == 1 ? 1'b1 : 1'($urandom_range(1)));
            insert_pct = 50;
            for (n = 0; n < SEGMENT_LEN; n++) begin
                // swing between filling and draining to reach full and empty
                if (n % 40 == 0)
                    case ($urandom_range(2))
                        0:       insert_pct = 33;
                        1:       insert_pct = 49;
                        default: insert_pct = 75;
                    endcase
                apply_cmd(pick_cmd(insert_pct), pick_value());
            end
        end

        idle_drain();
        repeat (CAPACITY + 4) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
